/* hw/rtl/wmfc_pkg.sv */
`timescale 1ns / 1ps

package wmfc_pkg;

  localparam logic [1:0] KIND_IGNORED = 2'd0;
  localparam logic [1:0] KIND_BEACON  = 2'd1;
  localparam logic [1:0] KIND_PROBE   = 2'd2;
  localparam logic [1:0] KIND_DEAUTH  = 2'd3;

  localparam logic [7:0] FC_TYPE_MASK = 8'h0C;
  localparam logic [3:0] SUBTYPE_MASK = 4'hF;
  localparam logic [3:0] SUB_BEACON   = 4'h8;
  localparam logic [3:0] SUB_PROBE    = 4'h4;
  localparam logic [3:0] SUB_DEAUTH   = 4'hC;

  localparam int MIN_FRAME_LEN = 24;
  localparam int ADDR_FIRST    = 10;
  localparam int ADDR_LAST     = 15;
  localparam int BODY_START    = 36;
  localparam int SSID_MARGIN   = 40;
  localparam logic [7:0] TAG_SSID = 8'd0;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_TAG  = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } walk_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] src;
    logic        found;
    logic [5:0]  slen;
  } job_t;

endpackage

/* hw/rtl/wmfc_front.sv */
`timescale 1ns / 1ps

module wmfc_front import wmfc_pkg::*; #(
  parameter int MAX_SSID_BYTES  = 32,
  parameter int MAX_FRAME_BYTES = 4096,
  parameter int SCAN_LIMIT      = 200,
  parameter int IDX_W           = 5,
  parameter int AW              = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_data,
  input  logic             frame_valid,
  output logic             frame_ready,
  input  logic [7:0]       frame_byte,
  input  logic             frame_end,
  input  logic             q_full,
  input  logic [PTR_W-1:0] bank,
  output logic             push,
  output job_t             job,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [7:0]       mem_wdata
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int OFF_W = $clog2(SCAN_LIMIT + 257);
  localparam int LEN_W = $clog2(MAX_SSID_BYTES + 1);
  localparam int CW    = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;

  logic              capture_enable;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        frame_control, frame_control_next;
  logic [47:0]       transmitter_address, transmitter_address_next;
  logic [OFF_W-1:0]  next_element_offset, next_element_offset_next;
  walk_phase_t       phase, phase_next;
  logic [7:0]        element_tag, element_tag_next;
  logic              walk_done, walk_done_next;
  logic              ssid_seen, ssid_seen_next;
  logic [OFF_W-1:0]  ssid_tag_offset, ssid_tag_offset_next;
  logic [LEN_W-1:0]  ssid_declared_length, ssid_declared_length_next;
  logic [LEN_W-1:0]  ssid_bytes_captured, ssid_bytes_captured_next;
  logic              take;
  logic              in_range;
  logic [3:0]        subtype;
  logic [1:0]        kind;
  logic              found;

  assign frame_ready = !q_full;
  assign take        = frame_valid && frame_ready;
  assign push        = take && frame_end;

  always_comb begin
    byte_position_next        = byte_position;
    frame_control_next        = frame_control;
    transmitter_address_next  = transmitter_address;
    next_element_offset_next  = next_element_offset;
    phase_next                = phase;
    element_tag_next          = element_tag;
    walk_done_next            = walk_done;
    ssid_seen_next            = ssid_seen;
    ssid_tag_offset_next      = ssid_tag_offset;
    ssid_declared_length_next = ssid_declared_length;
    ssid_bytes_captured_next  = ssid_bytes_captured;
    mem_we    = 1'b0;
    mem_waddr = {bank, IDX_W'(ssid_bytes_captured)};
    mem_wdata = frame_byte;
    in_range  = byte_position < POS_W'(MAX_FRAME_BYTES);

    if (take && in_range) begin
      if (byte_position == '0) begin
        frame_control_next = frame_byte;
      end
      if (byte_position >= POS_W'(ADDR_FIRST) && byte_position <= POS_W'(ADDR_LAST)) begin
        transmitter_address_next = {transmitter_address[39:0], frame_byte};
      end
      if (!walk_done) begin
        case (phase)
          PH_TAG: begin
            if (CW'(byte_position) == CW'(BODY_START) + CW'(next_element_offset)) begin
              if (next_element_offset >= OFF_W'(SCAN_LIMIT)) begin
                walk_done_next = 1'b1;
              end else begin
                element_tag_next = frame_byte;
                phase_next       = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            if (element_tag == TAG_SSID && frame_byte <= 8'(MAX_SSID_BYTES)) begin
              ssid_seen_next            = 1'b1;
              ssid_tag_offset_next      = next_element_offset;
              ssid_declared_length_next = LEN_W'(frame_byte);
              ssid_bytes_captured_next  = '0;
              if (frame_byte == 8'd0) begin
                walk_done_next = 1'b1;
              end else begin
                phase_next = PH_DATA;
              end
            end else begin
              next_element_offset_next =
                OFF_W'(next_element_offset + OFF_W'(2) + OFF_W'(frame_byte));
              phase_next = PH_TAG;
            end
          end
          PH_DATA: begin
            mem_we = 1'b1;
            ssid_bytes_captured_next = ssid_bytes_captured + LEN_W'(1);
            if (ssid_bytes_captured_next >= ssid_declared_length) begin
              walk_done_next = 1'b1;
            end
          end
          default: begin
            phase_next = PH_TAG;
          end
        endcase
      end
      byte_position_next = byte_position + POS_W'(1);
    end

    subtype = (frame_control_next[7:4]) & SUBTYPE_MASK;
    kind    = KIND_IGNORED;
    if (capture_enable && byte_position_next >= POS_W'(MIN_FRAME_LEN)
        && (frame_control_next & FC_TYPE_MASK) == 8'h00) begin
      if (subtype == SUB_BEACON) begin
        kind = KIND_BEACON;
      end else if (subtype == SUB_PROBE) begin
        kind = KIND_PROBE;
      end else if (subtype == SUB_DEAUTH) begin
        kind = KIND_DEAUTH;
      end
    end
    found = (kind == KIND_BEACON) && ssid_seen_next
            && (CW'(ssid_tag_offset_next) + CW'(SSID_MARGIN) < CW'(byte_position_next));
    job.kind  = kind;
    job.src   = (kind != KIND_IGNORED) ? transmitter_address_next : 48'd0;
    job.found = found;
    job.slen  = found ? 6'(ssid_bytes_captured_next) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
    end else if (cfg_write) begin
      capture_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_position        <= '0;
      frame_control        <= '0;
      transmitter_address  <= '0;
      next_element_offset  <= '0;
      phase                <= PH_TAG;
      element_tag          <= '0;
      walk_done            <= 1'b0;
      ssid_seen            <= 1'b0;
      ssid_tag_offset      <= '0;
      ssid_declared_length <= '0;
      ssid_bytes_captured  <= '0;
    end else if (take) begin
      byte_position        <= byte_position_next;
      frame_control        <= frame_control_next;
      transmitter_address  <= transmitter_address_next;
      next_element_offset  <= next_element_offset_next;
      phase                <= phase_next;
      element_tag          <= element_tag_next;
      walk_done            <= walk_done_next;
      ssid_seen            <= ssid_seen_next;
      ssid_tag_offset      <= ssid_tag_offset_next;
      ssid_declared_length <= ssid_declared_length_next;
      ssid_bytes_captured  <= ssid_bytes_captured_next;
    end
  end

endmodule

/* hw/rtl/wmfc_job_queue.sv */
`timescale 1ns / 1ps

module wmfc_job_queue import wmfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  job_t             push_job,
  output logic             full,
  output logic [PTR_W-1:0] wr_ptr,
  input  logic             pop,
  output logic             empty,
  output logic [PTR_W-1:0] rd_ptr,
  output job_t             head
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [CNT_W-1:0] count, count_next;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/wmfc_back.sv */
`timescale 1ns / 1ps

module wmfc_back import wmfc_pkg::*; #(
  parameter int IDX_W = 5,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             mem_we,
  input  logic [AW-1:0]    mem_waddr,
  input  logic [7:0]       mem_wdata,
  input  logic             q_empty,
  input  logic [PTR_W-1:0] q_rd_ptr,
  input  job_t             q_head,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [1:0]       frame_kind,
  output logic [47:0]      source_address,
  output logic             ssid_found,
  output logic [5:0]       ssid_length,
  output logic             is_ssid_byte,
  output logic [7:0]       ssid_byte,
  output logic [4:0]       ssid_index,
  output logic             last
);

  localparam int MEM_DEPTH = 1 << AW;

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rdata;
  logic [5:0]    k;
  logic [5:0]    k_prev;
  logic          issue;
  logic          s1_move;
  logic          s1_valid;
  job_t          s1_job;
  logic [5:0]    s1_k;
  logic          s1_last;

  assign k_prev  = k - 6'd1;
  assign s1_move = s1_valid && (!result_valid || result_ready);
  assign issue   = !q_empty && (!s1_valid || s1_move);
  assign pop     = issue && (k == q_head.slen);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata <= mem[{q_rd_ptr, IDX_W'(k_prev)}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_job  <= q_head;
      s1_k    <= k;
      s1_last <= k == q_head.slen;
    end
    if (s1_move) begin
      frame_kind     <= s1_job.kind;
      source_address <= s1_job.src;
      ssid_found     <= s1_job.found;
      ssid_length    <= s1_job.slen;
      is_ssid_byte   <= s1_k != 6'd0;
      ssid_byte      <= (s1_k == 6'd0) ? 8'd0 : rdata;
      ssid_index     <= (s1_k == 6'd0) ? 5'd0 : 5'(s1_k - 6'd1);
      last           <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k            <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (issue) begin
        k <= pop ? 6'd0 : k + 6'd1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/wifi_mgmt_frame_classifier_unit.sv */
`timescale 1ns / 1ps

// Channel    Handshake                    Payload
// frame      frame_valid / frame_ready    frame_byte, frame_end
// result     result_valid / result_ready  frame_kind .. last
// config     cfg_write (no wait)          cfg_data (capture_enable)
//
// One frame byte is taken per cycle while frame_ready is high.
// Each frame yields one summary and up to 32 SSID results, one per cycle when not held by
// result_ready, from a two-bank SSID memory; registered read port, two output stages.
// Reset is synchronous and clears the parser, the two-entry frame queue and result_valid.
// Bytes stall only while both queue slots, and so both SSID banks, are occupied.

module wifi_mgmt_frame_classifier_unit import wmfc_pkg::*; #(
  parameter int MAX_SSID_BYTES  = 32,
  parameter int MAX_FRAME_BYTES = 4096,
  parameter int SCAN_LIMIT      = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        frame_valid,
  output logic        frame_ready,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  frame_kind,
  output logic [47:0] source_address,
  output logic        ssid_found,
  output logic [5:0]  ssid_length,
  output logic        is_ssid_byte,
  output logic [7:0]  ssid_byte,
  output logic [4:0]  ssid_index,
  output logic        last
);

  localparam int IDX_W = (MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1;
  localparam int AW    = PTR_W + IDX_W;

  logic             q_full;
  logic             q_empty;
  logic [PTR_W-1:0] q_wr_ptr;
  logic [PTR_W-1:0] q_rd_ptr;
  logic             q_push;
  logic             q_pop;
  job_t             push_job;
  job_t             q_head;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;

  wmfc_front #(
    .MAX_SSID_BYTES (MAX_SSID_BYTES),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .SCAN_LIMIT     (SCAN_LIMIT),
    .IDX_W          (IDX_W),
    .AW             (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .q_full     (q_full),
    .bank       (q_wr_ptr),
    .push       (q_push),
    .job        (push_job),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  wmfc_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .wr_ptr  (q_wr_ptr),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_ptr  (q_rd_ptr),
    .head    (q_head)
  );

  wmfc_back #(
    .IDX_W(IDX_W),
    .AW   (AW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .q_empty       (q_empty),
    .q_rd_ptr      (q_rd_ptr),
    .q_head        (q_head),
    .pop           (q_pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .frame_kind    (frame_kind),
    .source_address(source_address),
    .ssid_found    (ssid_found),
    .ssid_length   (ssid_length),
    .is_ssid_byte  (is_ssid_byte),
    .ssid_byte     (ssid_byte),
    .ssid_index    (ssid_index),
    .last          (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("frame transaction pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_ssid_only_beacon: assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_kind != KIND_BEACON) |-> (!ssid_found && ssid_length == 6'd0))
    else $error("SSID reported for a frame that is not a beacon");

  a_last_position: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last && is_ssid_byte) |-> (6'(ssid_index) + 6'd1 == ssid_length))
    else $error("final SSID transaction at the wrong position");

endmodule

/* tb/sv/tb_wifi_mgmt_frame_classifier_unit.sv */
`timescale 1ns / 1ps

module tb_wifi_mgmt_frame_classifier_unit;
  import wmfc_pkg::*;

  localparam int MAX_SSID_BYTES  = 32;
  localparam int MAX_FRAME_BYTES = 4096;
  localparam int SCAN_LIMIT      = 200;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DIR_ROWS        = 19;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] src;
    logic        found;
    logic [5:0]  slen;
    logic        is_byte;
    logic [7:0]  sbyte;
    logic [4:0]  sidx;
    logic        last;
  } frame_report_t;

  typedef struct packed {
    bit         cap;
    logic [7:0] fc;
    logic [7:0] addr;
    int         flen;
    int         pad;
    logic [7:0] stag;
    int         slen;
    bit         typed;
    logic [1:0] kind;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        frame_valid = 1'b0;
  logic        frame_ready;
  logic [7:0]  frame_byte = 8'd0;
  logic        frame_end = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  frame_kind;
  logic [47:0] source_address;
  logic        ssid_found;
  logic [5:0]  ssid_length;
  logic        is_ssid_byte;
  logic [7:0]  ssid_byte;
  logic [4:0]  ssid_index;
  logic        last;

  always #5 clk = ~clk;

  wifi_mgmt_frame_classifier_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .frame_valid    (frame_valid),
    .frame_ready    (frame_ready),
    .frame_byte     (frame_byte),
    .frame_end      (frame_end),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .frame_kind     (frame_kind),
    .source_address (source_address),
    .ssid_found     (ssid_found),
    .ssid_length    (ssid_length),
    .is_ssid_byte   (is_ssid_byte),
    .ssid_byte      (ssid_byte),
    .ssid_index     (ssid_index),
    .last           (last)
  );

  // Parser state mirrored for prediction.
  bit          cap_en = 1'b0;
  int unsigned pos_cnt = 0;
  logic [7:0]  fc_r = 8'd0;
  logic [47:0] ta_r = 48'd0;
  int unsigned elem_off = 0;
  walk_phase_t walk_ph = PH_TAG;
  logic [7:0]  elem_tag = 8'd0;
  bit          walk_stop = 1'b0;
  bit          ssid_hit = 1'b0;
  int unsigned ssid_off = 0;
  int unsigned ssid_decl = 0;
  int unsigned ssid_cnt = 0;
  logic [7:0]  ssid_mem [32];

  frame_report_t pending_reports [$];
  logic [7:0]    frame_bytes [$];
  frame_row_t    dir_rows [DIR_ROWS];

  int unsigned faults = 0;
  int unsigned frames_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned reports_seen = 0;
  bit          calm = 1'b0;
  int unsigned hold = 0;

  function automatic frame_row_t frame_row(bit cap, logic [7:0] fc, logic [7:0] addr, int flen,
                                           int pad, logic [7:0] stag, int slen, bit typed,
                                           logic [1:0] kind);
    frame_row_t r;
    r.cap = cap;
    r.fc = fc;
    r.addr = addr;
    r.flen = flen;
    r.pad = pad;
    r.stag = stag;
    r.slen = slen;
    r.typed = typed;
    r.kind = kind;
    return r;
  endfunction

  function automatic void track_frame_byte(logic [7:0] b, bit fin, bit typed,
                                           logic [1:0] t_kind, logic [47:0] t_src);
    int unsigned flen;
    int unsigned slen;
    logic [1:0]  kind;
    logic [47:0] src;
    bit          found;
    frame_report_t r;
    kind = KIND_IGNORED;
    src = '0;
    found = 1'b0;
    slen = 0;
    if (pos_cnt < MAX_FRAME_BYTES) begin
      if (pos_cnt == 0) fc_r = b;
      if (pos_cnt >= ADDR_FIRST && pos_cnt <= ADDR_LAST) ta_r = {ta_r[39:0], b};
      if (!walk_stop) begin
        case (walk_ph)
          PH_TAG: begin
            if (pos_cnt == BODY_START + elem_off) begin
              if (elem_off >= SCAN_LIMIT) begin
                walk_stop = 1'b1;
              end else begin
                elem_tag = b;
                walk_ph = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            if (elem_tag == TAG_SSID && b <= MAX_SSID_BYTES) begin
              ssid_hit = 1'b1;
              ssid_off = elem_off;
              ssid_decl = b;
              ssid_cnt = 0;
              if (b == 0) walk_stop = 1'b1;
              else walk_ph = PH_DATA;
            end else begin
              elem_off += 2 + b;
              walk_ph = PH_TAG;
            end
          end
          default: begin
            ssid_mem[ssid_cnt % 32] = b;
            ssid_cnt++;
            if (ssid_cnt >= ssid_decl) walk_stop = 1'b1;
          end
        endcase
      end
      pos_cnt++;
    end
    if (!fin) return;

    flen = pos_cnt;
    if (cap_en && flen >= MIN_FRAME_LEN && (fc_r & FC_TYPE_MASK) == 8'd0) begin
      case (fc_r[7:4] & SUBTYPE_MASK)
        SUB_BEACON: kind = KIND_BEACON;
        SUB_PROBE:  kind = KIND_PROBE;
        SUB_DEAUTH: kind = KIND_DEAUTH;
        default:    kind = KIND_IGNORED;
      endcase
    end
    if (kind != KIND_IGNORED) src = ta_r;
    if (kind == KIND_BEACON && ssid_hit && ssid_off + SSID_MARGIN < flen) begin
      found = 1'b1;
      slen = ssid_cnt;
    end
    if (typed) begin
      kind = t_kind;
      src = t_src;
      found = 1'b0;
      slen = 0;
    end
    for (int k = 0; k <= slen; k++) begin
      r.kind = kind;
      r.src = src;
      r.found = found;
      r.slen = 6'(slen);
      r.is_byte = (k != 0);
      r.sbyte = (k == 0) ? 8'd0 : ssid_mem[k - 1];
      r.sidx = (k == 0) ? 5'd0 : 5'(k - 1);
      r.last = (k == slen);
      pending_reports.push_back(r);
    end

    pos_cnt = 0;
    fc_r = 8'd0;
    ta_r = 48'd0;
    elem_off = 0;
    walk_ph = PH_TAG;
    elem_tag = 8'd0;
    walk_stop = 1'b0;
    ssid_hit = 1'b0;
    ssid_off = 0;
    ssid_decl = 0;
    ssid_cnt = 0;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      faults++;
    end
  endfunction

  task automatic push_element(logic [7:0] tag, int len);
    frame_bytes.push_back(tag);
    frame_bytes.push_back(8'(len));
    repeat (len) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic make_random_frame();
    int unsigned n;
    int unsigned sel;
    int unsigned addr_mode;
    logic [7:0]  fc;
    frame_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 80);
      repeat (n) frame_bytes.push_back(8'($urandom));
      return;
    end
    sel = $urandom_range(0, 7);
    case (sel)
      0, 1, 2, 3: fc = {SUB_BEACON, 2'b00, 2'($urandom)};
      4:          fc = {SUB_PROBE, 2'b00, 2'($urandom)};
      5:          fc = {SUB_DEAUTH, 2'b00, 2'($urandom)};
      6:          fc = 8'($urandom);
      default:    fc = {4'($urandom), 2'b00, 2'($urandom)};
    endcase
    addr_mode = $urandom_range(0, 7);
    frame_bytes.push_back(fc);
    for (int j = 1; j < BODY_START; j++) begin
      if (j >= ADDR_FIRST && j <= ADDR_LAST && addr_mode >= 6)
        frame_bytes.push_back(addr_mode == 6 ? 8'h00 : 8'hFF);
      else
        frame_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 7) == 0)
      push_element(8'($urandom_range(1, 255)), $urandom_range(150, 220));
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 3) == 0)
        push_element(TAG_SSID, $urandom_range(MAX_SSID_BYTES + 1, 255));
      else
        push_element(8'($urandom_range(1, 255)),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20));
    end
    if ($urandom_range(0, 6) != 0) begin
      sel = $urandom_range(0, 5);
      push_element(TAG_SSID, (sel == 0) ? 0 : (sel == 1) ? MAX_SSID_BYTES :
                             $urandom_range(1, MAX_SSID_BYTES - 1));
    end
    repeat ($urandom_range(0, 2)) push_element(8'($urandom), $urandom_range(0, 12));
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      n = $urandom_range(1, frame_bytes.size());
      while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
    end else if (sel == 2) begin
      repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic send_byte(logic [7:0] b, bit fin, bit typed, logic [1:0] t_kind,
                           logic [47:0] t_src);
    if (!calm && $urandom_range(0, 7) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_byte <= b;
    frame_end <= fin;
    do @(posedge clk); while (!frame_ready);
    track_frame_byte(b, fin, typed, t_kind, t_src);
    bytes_sent++;
  endtask

  task automatic send_frame(bit typed, logic [1:0] t_kind, logic [47:0] t_src);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, typed, t_kind, t_src);
    frames_sent++;
  endtask

  // The register may only change while the block holds no frame.
  task automatic set_capture(bit v);
    frame_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    cap_en = v;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold <= 0;
    end else if (hold != 0) begin
      hold <= hold - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      result_ready <= 1'b0;
      hold <= $urandom_range(0, 9);
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : report_check
    frame_report_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with no frame outstanding");
        faults++;
      end else begin
        want = pending_reports.pop_front();
        check_field("frame_kind", want.kind, frame_kind);
        check_field("source_address", want.src, source_address);
        check_field("ssid_found", want.found, ssid_found);
        check_field("ssid_length", want.slen, ssid_length);
        check_field("is_ssid_byte", want.is_byte, is_ssid_byte);
        check_field("ssid_byte", want.sbyte, ssid_byte);
        check_field("ssid_index", want.sidx, ssid_index);
        check_field("last", want.last, last);
        reports_seen++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    frame_row_t  row;
    bit          phase_cap [4];
    int unsigned phase_frames [4];
    phase_cap = '{1'b1, 1'b0, 1'b1, 1'b1};
    phase_frames = '{20, 6, 14, 8};

    dir_rows[0]  = frame_row(1'b0, 8'h80, 8'h5A, 0, -1, TAG_SSID, 8, 1'b1, KIND_IGNORED);
    dir_rows[1]  = frame_row(1'b1, 8'h80, 8'h11, 1, -1, TAG_SSID, -1, 1'b1, KIND_IGNORED);
    dir_rows[2]  = frame_row(1'b1, 8'h80, 8'h22, 23, -1, TAG_SSID, -1, 1'b1, KIND_IGNORED);
    dir_rows[3]  = frame_row(1'b1, 8'h80, 8'hFF, 24, -1, TAG_SSID, -1, 1'b1, KIND_BEACON);
    dir_rows[4]  = frame_row(1'b1, 8'h40, 8'h00, 30, -1, TAG_SSID, -1, 1'b1, KIND_PROBE);
    dir_rows[5]  = frame_row(1'b1, 8'hC0, 8'hFF, 26, -1, TAG_SSID, -1, 1'b1, KIND_DEAUTH);
    dir_rows[6]  = frame_row(1'b1, 8'h88, 8'h33, 40, -1, TAG_SSID, 4, 1'b1, KIND_IGNORED);
    dir_rows[7]  = frame_row(1'b1, 8'h00, 8'h44, 40, -1, TAG_SSID, 4, 1'b1, KIND_IGNORED);
    dir_rows[8]  = frame_row(1'b1, 8'h83, 8'h55, 0, -1, TAG_SSID, 32, 1'b0, KIND_BEACON);
    dir_rows[9]  = frame_row(1'b1, 8'h80, 8'h66, 50, -1, TAG_SSID, 0, 1'b0, KIND_BEACON);
    dir_rows[10] = frame_row(1'b1, 8'h80, 8'h77, 0, -1, TAG_SSID, 33, 1'b0, KIND_BEACON);
    dir_rows[11] = frame_row(1'b1, 8'h80, 8'h88, 45, -1, TAG_SSID, 20, 1'b0, KIND_BEACON);
    dir_rows[12] = frame_row(1'b1, 8'h80, 8'h99, 52, 10, TAG_SSID, 6, 1'b0, KIND_BEACON);
    dir_rows[13] = frame_row(1'b1, 8'h80, 8'hAA, 53, 10, TAG_SSID, 6, 1'b0, KIND_BEACON);
    dir_rows[14] = frame_row(1'b1, 8'h80, 8'hBB, 300, 198, TAG_SSID, 4, 1'b0, KIND_BEACON);
    dir_rows[15] = frame_row(1'b1, 8'h80, 8'hCC, 300, 196, TAG_SSID, 4, 1'b0, KIND_BEACON);
    dir_rows[16] = frame_row(1'b1, 8'h80, 8'hDD, 0, -1, 8'h01, 5, 1'b0, KIND_BEACON);
    dir_rows[17] = frame_row(1'b1, 8'h80, 8'hEE, 35, -1, TAG_SSID, 3, 1'b0, KIND_BEACON);
    dir_rows[18] = frame_row(1'b1, 8'h80, 8'hF0, 4100, -1, TAG_SSID, 5, 1'b0, KIND_BEACON);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_capture(1'b0);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.cap != cap_en) set_capture(row.cap);
      frame_bytes.delete();
      frame_bytes.push_back(row.fc);
      for (int j = 1; j < BODY_START; j++)
        frame_bytes.push_back((j >= ADDR_FIRST && j <= ADDR_LAST) ? row.addr : 8'($urandom));
      if (row.pad >= 0) push_element(8'h01, row.pad);
      if (row.slen >= 0) push_element(row.stag, row.slen);
      if (row.flen > 0) begin
        while (frame_bytes.size() < row.flen) frame_bytes.push_back(8'($urandom));
        while (frame_bytes.size() > row.flen) void'(frame_bytes.pop_back());
      end
      send_frame(row.typed, row.kind, (row.kind == KIND_IGNORED) ? 48'd0 : {6{row.addr}});
    end

    for (int p = 0; p < 4; p++) begin
      set_capture(phase_cap[p]);
      calm = (p == 3);
      for (int f = 0; f < phase_frames[p]; f++) begin
        make_random_frame();
        send_frame(1'b0, KIND_IGNORED, 48'd0);
      end
    end

    frame_valid <= 1'b0;
    for (int w = 0; w < 20000 && pending_reports.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      faults++;
    end

    $display("Sent %0d frames (%0d bytes) with capture on and off; %0d results checked.",
             frames_sent, bytes_sent, reports_seen);
    $display("Frames covered short, overlong, scan-limit, truncated and empty-SSID cases.");
    if (faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* wifi_mgmt_frame_classifier_unit.f */
hw/rtl/wmfc_pkg.sv
hw/rtl/wmfc_front.sv
hw/rtl/wmfc_job_queue.sv
hw/rtl/wmfc_back.sv
hw/rtl/wifi_mgmt_frame_classifier_unit.sv
tb/sv/tb_wifi_mgmt_frame_classifier_unit.sv
